// ===== rtl/emc_pkg.sv =====
// ----------------------------------------------------------------------------
// EAP MS-CHAPv2 packet classifier package
// Result kinds, protocol codes, byte positions and the hex digit decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package emc_pkg;

  typedef enum logic [2:0] {
    KIND_INVALID        = 3'd0,
    KIND_IDENTITY_REQ   = 3'd1,
    KIND_CHALLENGE      = 3'd2,
    KIND_RESULT_SUCCESS = 3'd3,
    KIND_RESULT_FAILURE = 3'd4,
    KIND_EAP_SUCCESS    = 3'd5,
    KIND_EAP_FAILURE    = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    CFG_DIGEST_UPPER  = 2'd0,
    CFG_DIGEST_MIDDLE = 2'd1,
    CFG_DIGEST_LOWER  = 2'd2
  } cfg_index_t;

  localparam logic [7:0] EAP_REQUEST   = 8'd1;
  localparam logic [7:0] EAP_SUCCESS   = 8'd3;
  localparam logic [7:0] EAP_FAILURE   = 8'd4;
  localparam logic [7:0] TYPE_IDENTITY = 8'd1;
  localparam logic [7:0] TYPE_MSCHAPV2 = 8'd26;
  localparam logic [7:0] OP_CHALLENGE  = 8'd1;
  localparam logic [7:0] OP_SUCCESS    = 8'd3;
  localparam logic [7:0] OP_FAILURE    = 8'd4;
  localparam logic [7:0] CHALLENGE_SIZE = 8'd16;
  localparam logic [7:0] CHAR_S        = 8'h53;
  localparam logic [7:0] CHAR_EQUALS   = 8'h3D;

  localparam logic [15:0] POS_CODE        = 16'd0;
  localparam logic [15:0] POS_IDENT       = 16'd1;
  localparam logic [15:0] POS_LEN_HI      = 16'd2;
  localparam logic [15:0] POS_LEN_LO      = 16'd3;
  localparam logic [15:0] POS_TYPE        = 16'd4;
  localparam logic [15:0] POS_OPCODE      = 16'd5;
  localparam logic [15:0] POS_INNER_IDENT = 16'd6;
  localparam logic [15:0] POS_INNER_HI    = 16'd7;
  localparam logic [15:0] POS_INNER_LO    = 16'd8;
  localparam logic [15:0] POS_VALUE_SIZE  = 16'd9;
  localparam logic [15:0] POS_VALUE_FIRST = 16'd10;
  localparam logic [15:0] POS_VALUE_END   = 16'd26;
  localparam logic [15:0] POS_HEX_FIRST   = 16'd11;
  localparam logic [15:0] POS_HEX_LAST    = 16'd50;

  localparam logic [15:0] LEN_HEADER      = 16'd4;
  localparam logic [15:0] LEN_TYPE        = 16'd5;
  localparam logic [15:0] LEN_RESULT      = 16'd9;
  localparam logic [15:0] LEN_CHALLENGE   = 16'd26;
  localparam logic [15:0] MIN_AUTH_MSG    = 16'd42;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

  // Returns {error, nibble}; only digits and uppercase A to F are accepted.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else begin
      r = 5'b1_0000;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/eap_mschapv2_packet_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// EAP MS-CHAPv2 packet classifier
// Classifies one received EAP packet, byte by byte, and checks the S=
// authenticator of a success result against a configured 20-byte digest.
// ----------------------------------------------------------------------------
// Usage: packet bytes enter on the in_ stream, one byte per item, with
// in_tlast on the final byte of the buffer. Each byte within the header or
// the declared length updates the captured header fields and the digest
// check. The final byte produces one classification item on the out_
// stream, registered in the cycle after it is accepted. Packets may follow
// one another without a gap, and a new byte may be accepted in every cycle
// unless a final byte waits. If the receiver stalls on a held result, the
// non-final bytes of the next packet are still accepted; only a further
// final byte waits until the held result is taken. The cfg_ channel writes
// the three digest registers (index 0 upper, 1 middle, 2 lower) and is always
// ready. Synchronous active-low reset clears the digest registers, the packet
// progress and the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eap_mschapv2_packet_classifier_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // data_byte
  input  wire logic         in_tlast,   // last_byte
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // packet_kind[2:0], eap_ident[10:3], mschap_identifier[18:11],
  // challenge_high[82:19], challenge_low[146:83], message_length[162:147],
  // authenticator_ok[163], zero fill[167:164]
  output logic [167:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  import emc_pkg::*;

  logic [63:0] digest_upper_r, digest_middle_r;
  logic [31:0] digest_lower_r;

  logic [15:0] byte_count_r, byte_count_nxt;
  logic [7:0]  code_byte_r, code_byte_nxt;
  logic [7:0]  ident_byte_r, ident_byte_nxt;
  logic [15:0] declared_length_r, declared_length_nxt;
  logic [7:0]  type_byte_r, type_byte_nxt;
  logic [7:0]  opcode_byte_r, opcode_byte_nxt;
  logic [7:0]  inner_ident_r, inner_ident_nxt;
  logic [15:0] inner_length_r, inner_length_nxt;
  logic [7:0]  value_size_r, value_size_nxt;
  logic [7:0]  challenge_r [16];
  logic [7:0]  challenge_nxt [16];
  logic        prefix_ok_r, prefix_ok_nxt;
  logic [3:0]  hex_high_r, hex_high_nxt;
  logic        hex_error_r, hex_error_nxt;
  logic        mismatch_r, mismatch_nxt;

  logic        out_valid_r;
  logic [167:0] out_data_r, out_data_nxt;

  logic        in_accept, out_accept, take;
  logic [7:0]  digest_bytes [20];
  logic [3:0]  store_idx;
  logic [5:0]  hex_pos;
  logic [4:0]  hex_val;
  logic [7:0]  full_byte;

  kind_t       kind;
  logic        len_ok;
  logic [7:0]  eid, mid;
  logic [63:0] chi, clo;
  logic [15:0] mlen, plen;
  logic        aok;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign in_tready  = !out_valid_r || out_tready || !in_tlast;
  assign in_accept  = in_tvalid && in_tready;
  assign out_accept = out_valid_r && out_tready;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      digest_bytes[i]     = digest_upper_r[63 - 8 * i -: 8];
      digest_bytes[i + 8] = digest_middle_r[63 - 8 * i -: 8];
    end
    for (int i = 0; i < 4; i++) begin
      digest_bytes[i + 16] = digest_lower_r[31 - 8 * i -: 8];
    end
  end

  assign take      = (byte_count_r < LEN_HEADER) || (byte_count_r < declared_length_r);
  assign store_idx = byte_count_r[3:0] - 4'd10;
  assign hex_pos   = byte_count_r[5:0] - 6'd11;
  assign hex_val   = hex_decode(in_tdata);
  assign full_byte = {hex_high_r, hex_val[3:0]};

  always_comb begin
    byte_count_nxt      = byte_count_r;
    code_byte_nxt       = code_byte_r;
    ident_byte_nxt      = ident_byte_r;
    declared_length_nxt = declared_length_r;
    type_byte_nxt       = type_byte_r;
    opcode_byte_nxt     = opcode_byte_r;
    inner_ident_nxt     = inner_ident_r;
    inner_length_nxt    = inner_length_r;
    value_size_nxt      = value_size_r;
    challenge_nxt       = challenge_r;
    prefix_ok_nxt       = prefix_ok_r;
    hex_high_nxt        = hex_high_r;
    hex_error_nxt       = hex_error_r;
    mismatch_nxt        = mismatch_r;
    if (in_accept && take) begin
      case (byte_count_r)
        POS_CODE:        code_byte_nxt = in_tdata;
        POS_IDENT:       ident_byte_nxt = in_tdata;
        POS_LEN_HI:      declared_length_nxt = {in_tdata, declared_length_r[7:0]};
        POS_LEN_LO:      declared_length_nxt = {declared_length_r[15:8], in_tdata};
        POS_TYPE:        type_byte_nxt = in_tdata;
        POS_OPCODE:      opcode_byte_nxt = in_tdata;
        POS_INNER_IDENT: inner_ident_nxt = in_tdata;
        POS_INNER_HI:    inner_length_nxt = {in_tdata, inner_length_r[7:0]};
        POS_INNER_LO:    inner_length_nxt = {inner_length_r[15:8], in_tdata};
        POS_VALUE_SIZE:  value_size_nxt = in_tdata;
        default: begin
          if (byte_count_r >= POS_VALUE_FIRST && byte_count_r < POS_VALUE_END) begin
            challenge_nxt[store_idx] = in_tdata;
          end
          if (byte_count_r == POS_VALUE_FIRST) begin
            prefix_ok_nxt = (value_size_r == CHAR_S) && (in_tdata == CHAR_EQUALS);
          end
          if (byte_count_r >= POS_HEX_FIRST && byte_count_r <= POS_HEX_LAST) begin
            if (hex_val[4]) begin
              hex_error_nxt = 1'b1;
            end
            if (!hex_pos[0]) begin
              hex_high_nxt = hex_val[3:0];
            end else if (full_byte != digest_bytes[hex_pos[5:1]]) begin
              mismatch_nxt = 1'b1;
            end
          end
        end
      endcase
    end
    if (in_accept && byte_count_r != COUNT_MAX) begin
      byte_count_nxt = byte_count_r + 16'd1;
    end
  end

  always_comb begin
    plen   = declared_length_nxt;
    len_ok = (byte_count_nxt >= LEN_HEADER) && (plen >= LEN_HEADER) &&
             (plen <= byte_count_nxt);
    kind   = KIND_INVALID;
    eid    = 8'd0;
    mid    = 8'd0;
    chi    = 64'd0;
    clo    = 64'd0;
    mlen   = 16'd0;
    aok    = 1'b0;
    if (len_ok) begin
      if (code_byte_nxt == EAP_REQUEST && plen >= LEN_TYPE &&
          type_byte_nxt == TYPE_IDENTITY) begin
        kind = KIND_IDENTITY_REQ;
      end else if (code_byte_nxt == EAP_REQUEST && plen >= LEN_CHALLENGE &&
                   type_byte_nxt == TYPE_MSCHAPV2 && opcode_byte_nxt == OP_CHALLENGE &&
                   inner_length_nxt == plen - LEN_TYPE &&
                   value_size_nxt == CHALLENGE_SIZE) begin
        kind = KIND_CHALLENGE;
        mid  = inner_ident_nxt;
        for (int i = 0; i < 8; i++) begin
          chi[63 - 8 * i -: 8] = challenge_nxt[i];
          clo[63 - 8 * i -: 8] = challenge_nxt[i + 8];
        end
      end else if (code_byte_nxt == EAP_REQUEST && plen >= LEN_RESULT &&
                   type_byte_nxt == TYPE_MSCHAPV2 &&
                   (opcode_byte_nxt == OP_SUCCESS || opcode_byte_nxt == OP_FAILURE) &&
                   inner_length_nxt == plen - LEN_TYPE) begin
        kind = (opcode_byte_nxt == OP_SUCCESS) ? KIND_RESULT_SUCCESS : KIND_RESULT_FAILURE;
        mlen = plen - LEN_RESULT;
        aok  = (opcode_byte_nxt == OP_SUCCESS) && (mlen >= MIN_AUTH_MSG) &&
               prefix_ok_nxt && !hex_error_nxt && !mismatch_nxt;
      end else if (plen == LEN_HEADER &&
                   (code_byte_nxt == EAP_SUCCESS || code_byte_nxt == EAP_FAILURE)) begin
        kind = (code_byte_nxt == EAP_SUCCESS) ? KIND_EAP_SUCCESS : KIND_EAP_FAILURE;
      end
      if (kind != KIND_INVALID) begin
        eid = ident_byte_nxt;
      end
    end
    out_data_nxt = {4'd0, aok, mlen, clo, chi, mid, eid, kind};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digest_upper_r  <= 64'd0;
      digest_middle_r <= 64'd0;
      digest_lower_r  <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIGEST_UPPER:  digest_upper_r  <= cfg_data;
        CFG_DIGEST_MIDDLE: digest_middle_r <= cfg_data;
        CFG_DIGEST_LOWER:  digest_lower_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_accept && in_tlast)) begin
      byte_count_r      <= 16'd0;
      code_byte_r       <= 8'd0;
      ident_byte_r      <= 8'd0;
      declared_length_r <= 16'd0;
      type_byte_r       <= 8'd0;
      opcode_byte_r     <= 8'd0;
      inner_ident_r     <= 8'd0;
      inner_length_r    <= 16'd0;
      value_size_r      <= 8'd0;
      prefix_ok_r       <= 1'b0;
      hex_high_r        <= 4'd0;
      hex_error_r       <= 1'b0;
      mismatch_r        <= 1'b0;
    end else begin
      byte_count_r      <= byte_count_nxt;
      code_byte_r       <= code_byte_nxt;
      ident_byte_r      <= ident_byte_nxt;
      declared_length_r <= declared_length_nxt;
      type_byte_r       <= type_byte_nxt;
      opcode_byte_r     <= opcode_byte_nxt;
      inner_ident_r     <= inner_ident_nxt;
      inner_length_r    <= inner_length_nxt;
      value_size_r      <= value_size_nxt;
      prefix_ok_r       <= prefix_ok_nxt;
      hex_high_r        <= hex_high_nxt;
      hex_error_r       <= hex_error_nxt;
      mismatch_r        <= mismatch_nxt;
    end
  end

  // The challenge bytes are read only for a challenge result, which implies
  // that all sixteen were written in the same packet.
  always_ff @(posedge clk) begin
    challenge_r <= challenge_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_accept) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_tlast) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire
